/* hdl/packed_pattern_stream_parser_top_defines.svh */
// Assertion macros shared by the parser's checker.
`ifndef PACKED_PATTERN_STREAM_PARSER_TOP_DEFINES_SVH
`define PACKED_PATTERN_STREAM_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PPSP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppsp check failed");

// Next-cycle implication, disabled while reset is high.
`define PPSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppsp check failed");

`endif

/* hdl/ppsp_pkg.sv */
// Types and constants of the packed pattern stream parser.
package ppsp_pkg;

   typedef enum logic [2:0] {
      PH_FLAG = 3'd0,
      PH_NOTE = 3'd1,
      PH_INS  = 3'd2,
      PH_VOL  = 3'd3,
      PH_CMD  = 3'd4,
      PH_INFO = 3'd5
   } phase_type;

   localparam logic       KIND_CELL = 1'b0;
   localparam logic       KIND_DONE = 1'b1;

   localparam int         BIT_NOTE  = 5;
   localparam int         BIT_VOL   = 6;
   localparam int         BIT_CMD   = 7;

   localparam logic [7:0] VOL_MAX   = 8'd64;

   typedef struct packed {
      logic       kind;
      logic [1:0] channel;
      logic [5:0] row;
      logic       has_note;
      logic [7:0] note;
      logic [7:0] instrument;
      logic       has_volume;
      logic [6:0] volume;
      logic       has_command;
      logic [7:0] command;
      logic [7:0] info;
   } rsp_payload_type;

endpackage

/* hdl/ppsp_if.sv */
// Valid/ready channel interfaces for the parser's byte input and result output.
interface ppsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ppsp_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [1:0] channel;
   logic [5:0] row;
   logic       has_note;
   logic [7:0] note;
   logic [7:0] instrument;
   logic       has_volume;
   logic [6:0] volume;
   logic       has_command;
   logic [7:0] command;
   logic [7:0] info;

   modport source (output valid, output kind, output channel, output row,
                   output has_note, output note, output instrument,
                   output has_volume, output volume, output has_command,
                   output command, output info, input ready);
   modport sink   (input valid, input kind, input channel, input row,
                   input has_note, input note, input instrument,
                   input has_volume, input volume, input has_command,
                   input command, input info, output ready);
endinterface

/* hdl/packed_pattern_stream_parser_top.sv */
// Packed pattern stream parser: byte-wise decoder of packed tracker pattern rows.
//
// req_bus carries one pattern byte per transaction. A zero flag byte ends a row;
// a nonzero flag names a channel and which of note+instrument, volume and
// command+info bytes follow. rsp_bus carries one cell update when an event's
// last byte is taken (kind 0), or a pattern-done transaction (kind 1) when the
// last of NUM_ROWS rows ends, after which the row count wraps to 0.
// Events for channels at or above NUM_CHANNELS and flags with no parts give
// no transaction.
// Throughput: one byte per cycle while req_bus.ready is high; each byte updates the
// parse state in the cycle it is taken. Latency: a result is on rsp_bus the cycle
// after the byte that completes it.
// The result register is the only buffer: req_bus.ready is high while it is
// empty or being drained, so a stalled receiver holds off input exactly one
// result deep and nothing is dropped.
// Reset (synchronous, active high) returns to the flag phase at row 0 with no
// result pending.
module packed_pattern_stream_parser_top
   import ppsp_pkg::*;
#(
   parameter int NUM_CHANNELS = 4,
   parameter int NUM_ROWS     = 64
) (
   input  logic       clock,
   input  logic       reset,
   ppsp_req_if.sink   req_bus,
   ppsp_rsp_if.source rsp_bus
);

   localparam int               ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROWS - 1);

   phase_type       phase_ff, phase_in;
   logic [7:0]      flag_ff, flag_in;
   logic [7:0]      note_ff, note_in;
   logic [7:0]      ins_ff, ins_in;
   logic [6:0]      vol_ff, vol_in;
   logic [7:0]      cmd_ff, cmd_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   logic       accept;
   logic [7:0] din;
   logic [7:0] info_val;
   logic [6:0] vol_clamped;
   logic       emit_cell;
   logic       emit_done;
   logic       ch_ok;
   logic [8:0] row_wide;

   assign din          = req_bus.data_byte;
   assign req_bus.ready = !out_valid_ff || rsp_bus.ready;
   assign accept       = req_bus.valid && req_bus.ready;
   assign vol_clamped  = (din > VOL_MAX) ? VOL_MAX[6:0] : din[6:0];
   assign ch_ok        = ({1'b0, flag_ff[4:0]} < 6'(NUM_CHANNELS));
   assign row_wide     = 9'(row_ff);

   // next parse state
   always_comb begin
      phase_in  = phase_ff;
      flag_in   = flag_ff;
      note_in   = note_ff;
      ins_in    = ins_ff;
      vol_in    = vol_ff;
      cmd_in    = cmd_ff;
      row_in    = row_ff;
      info_val  = 8'd0;
      emit_cell = 1'b0;
      emit_done = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_NOTE: begin
               note_in  = din;
               phase_in = PH_INS;
            end
            PH_INS: begin
               ins_in = din;
               if (flag_ff[BIT_VOL]) begin
                  phase_in = PH_VOL;
               end else if (flag_ff[BIT_CMD]) begin
                  phase_in = PH_CMD;
               end else begin
                  phase_in  = PH_FLAG;
                  emit_cell = 1'b1;
               end
            end
            PH_VOL: begin
               vol_in = vol_clamped;
               if (flag_ff[BIT_CMD]) begin
                  phase_in = PH_CMD;
               end else begin
                  phase_in  = PH_FLAG;
                  emit_cell = 1'b1;
               end
            end
            PH_CMD: begin
               cmd_in   = din;
               phase_in = PH_INFO;
            end
            PH_INFO: begin
               info_val  = din;
               phase_in  = PH_FLAG;
               emit_cell = 1'b1;
            end
            default: begin
               phase_in = PH_FLAG;
               if (din == 8'd0) begin
                  if (row_ff == ROW_LAST) begin
                     row_in    = '0;
                     emit_done = 1'b1;
                  end else begin
                     row_in = row_ff + ROW_W'(1);
                  end
               end else begin
                  flag_in = din;
                  note_in = 8'd0;
                  ins_in  = 8'd0;
                  vol_in  = 7'd0;
                  cmd_in  = 8'd0;
                  if (din[BIT_NOTE]) begin
                     phase_in = PH_NOTE;
                  end else if (din[BIT_VOL]) begin
                     phase_in = PH_VOL;
                  end else if (din[BIT_CMD]) begin
                     phase_in = PH_CMD;
                  end
               end
            end
         endcase
      end
   end

   // result register load
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (emit_done) begin
         out_in       = '0;
         out_in.kind  = KIND_DONE;
         out_valid_in = 1'b1;
      end else if (emit_cell && ch_ok) begin
         out_in.kind        = KIND_CELL;
         out_in.channel     = flag_ff[1:0];
         out_in.row         = row_wide[5:0];
         out_in.has_note    = flag_ff[BIT_NOTE];
         out_in.note        = note_in;
         out_in.instrument  = ins_in;
         out_in.has_volume  = flag_ff[BIT_VOL];
         out_in.volume      = vol_in;
         out_in.has_command = flag_ff[BIT_CMD];
         out_in.command     = cmd_in;
         out_in.info        = info_val;
         out_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FLAG;
         flag_ff      <= 8'd0;
         note_ff      <= 8'd0;
         ins_ff       <= 8'd0;
         vol_ff       <= 7'd0;
         cmd_ff       <= 8'd0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         flag_ff      <= flag_in;
         note_ff      <= note_in;
         ins_ff       <= ins_in;
         vol_ff       <= vol_in;
         cmd_ff       <= cmd_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.kind        = out_ff.kind;
   assign rsp_bus.channel     = out_ff.channel;
   assign rsp_bus.row         = out_ff.row;
   assign rsp_bus.has_note    = out_ff.has_note;
   assign rsp_bus.note        = out_ff.note;
   assign rsp_bus.instrument  = out_ff.instrument;
   assign rsp_bus.has_volume  = out_ff.has_volume;
   assign rsp_bus.volume      = out_ff.volume;
   assign rsp_bus.has_command = out_ff.has_command;
   assign rsp_bus.command     = out_ff.command;
   assign rsp_bus.info        = out_ff.info;

endmodule

/* hdl/ppsp_checker.sv */
// Port-level assertion checker for the packed pattern stream parser, with its bind.
`include "packed_pattern_stream_parser_top_defines.svh"

module ppsp_checker
   import ppsp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [1:0] rsp_channel,
   input logic [5:0] rsp_row,
   input logic       rsp_has_note,
   input logic [7:0] rsp_note,
   input logic [7:0] rsp_instrument,
   input logic       rsp_has_volume,
   input logic [6:0] rsp_volume,
   input logic       rsp_has_command,
   input logic [7:0] rsp_command,
   input logic [7:0] rsp_info
);

   `PPSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_channel) && $stable(rsp_row) && $stable(rsp_volume) && $stable(rsp_note) && $stable(rsp_info))
   `PPSP_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `PPSP_ASSERT_NOW(a_done_fields_zero, clock, reset, rsp_valid && rsp_kind == KIND_DONE, rsp_channel == 2'd0 && rsp_row == 6'd0 && !rsp_has_note && !rsp_has_volume && !rsp_has_command && rsp_info == 8'd0)
   `PPSP_ASSERT_NOW(a_volume_range, clock, reset, rsp_valid && rsp_has_volume, rsp_volume <= VOL_MAX[6:0])
   `PPSP_ASSERT_NOW(a_absent_parts_zero, clock, reset, rsp_valid && rsp_kind == KIND_CELL, (rsp_has_note || (rsp_note == 8'd0 && rsp_instrument == 8'd0)) && (rsp_has_volume || rsp_volume == 7'd0) && (rsp_has_command || (rsp_command == 8'd0 && rsp_info == 8'd0)))

endmodule

bind packed_pattern_stream_parser_top ppsp_checker u_ppsp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_kind        (rsp_bus.kind),
   .rsp_channel     (rsp_bus.channel),
   .rsp_row         (rsp_bus.row),
   .rsp_has_note    (rsp_bus.has_note),
   .rsp_note        (rsp_bus.note),
   .rsp_instrument  (rsp_bus.instrument),
   .rsp_has_volume  (rsp_bus.has_volume),
   .rsp_volume      (rsp_bus.volume),
   .rsp_has_command (rsp_bus.has_command),
   .rsp_command     (rsp_bus.command),
   .rsp_info        (rsp_bus.info)
);
